// ===== design/bpd_pkg.sv =====
// Package for the bill pulse train decoder: shared types, widths, constants
// and the pulse-count to bill-value lookup. No dependencies.
`timescale 1ns / 1ps

package bpd_pkg;

  // Widths
  localparam int TIME_WIDTH   = 21;
  localparam int TICK_CFG_W   = 20;
  localparam int CREDIT_W     = 16;
  localparam int VALUE_W      = 7;
  localparam int COUNT_W      = 4;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;

  localparam logic [TIME_WIDTH-1:0] TIME_MAX   = '1;
  localparam logic [COUNT_W-1:0]    COUNT_MAX  = '1;
  localparam logic [CREDIT_W-1:0]   CREDIT_MAX = '1;

  // Register indexes (word address paddr[3:2])
  localparam logic [1:0] REG_ENABLE   = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE = 2'd1;
  localparam logic [1:0] REG_TIMEOUT  = 2'd2;
  localparam logic [1:0] REG_FARE     = 2'd3;

  // Reset values
  localparam logic [TICK_CFG_W-1:0] DEBOUNCE_RST = 20'd30000;
  localparam logic [TICK_CFG_W-1:0] TIMEOUT_RST  = 20'd200000;

  // Recognized trains
  localparam logic [COUNT_W-1:0] COUNT_BILL_20  = 4'd2;
  localparam logic [COUNT_W-1:0] COUNT_BILL_50  = 4'd5;
  localparam logic [COUNT_W-1:0] COUNT_BILL_100 = 4'd10;
  localparam logic [VALUE_W-1:0] VALUE_BILL_20  = 7'd20;
  localparam logic [VALUE_W-1:0] VALUE_BILL_50  = 7'd50;
  localparam logic [VALUE_W-1:0] VALUE_BILL_100 = 7'd100;
  localparam logic [VALUE_W-1:0] VALUE_NONE     = 7'd0;

  typedef struct packed {
    logic                  enable;
    logic [TICK_CFG_W-1:0] debounce_ticks;
    logic [TICK_CFG_W-1:0] timeout_ticks;
    logic [CREDIT_W-1:0]   fare;
  } bpd_cfg_t;

  typedef struct packed {
    logic                edge_req;
    logic [CREDIT_W-1:0] coin_credit;
  } bpd_item_t;

  typedef struct packed {
    logic [CREDIT_W-1:0] bill_credit;
    logic [VALUE_W-1:0]  bill_value;
    logic                unknown_bill;
    logic                fare_paid;
  } bpd_result_t;

  // Bill value of a finished train, zero when the count is not recognized
  function automatic logic [VALUE_W-1:0] bill_value_of(input logic [COUNT_W-1:0] count);
    logic [VALUE_W-1:0] v;
    case (count)
      COUNT_BILL_20:  v = VALUE_BILL_20;
      COUNT_BILL_50:  v = VALUE_BILL_50;
      COUNT_BILL_100: v = VALUE_BILL_100;
      default:        v = VALUE_NONE;
    endcase
    return v;
  endfunction

endpackage

// ===== design/bpd_regs.sv =====
// Configuration register file on an APB-style port.
// Depends on bpd_pkg for the register map and the config struct.
`timescale 1ns / 1ps

module bpd_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpd_pkg::ADDR_W-1:0]  paddr,
  input  logic [bpd_pkg::DATA_W-1:0]  pwdata,
  output logic [bpd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output bpd_pkg::bpd_cfg_t           cfg
);
  import bpd_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable         <= 1'b0;
      cfg.debounce_ticks <= DEBOUNCE_RST;
      cfg.timeout_ticks  <= TIMEOUT_RST;
      cfg.fare           <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ENABLE:   cfg.enable         <= pwdata[0];
        REG_DEBOUNCE: cfg.debounce_ticks <= pwdata[TICK_CFG_W-1:0];
        REG_TIMEOUT:  cfg.timeout_ticks  <= pwdata[TICK_CFG_W-1:0];
        REG_FARE:     cfg.fare           <= pwdata[CREDIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_ENABLE:   prdata[0]              = cfg.enable;
      REG_DEBOUNCE: prdata[TICK_CFG_W-1:0] = cfg.debounce_ticks;
      REG_TIMEOUT:  prdata[TICK_CFG_W-1:0] = cfg.timeout_ticks;
      REG_FARE:     prdata[CREDIT_W-1:0]   = cfg.fare;
      default:      prdata                 = '0;
    endcase
  end

endmodule

// ===== design/bpd_core.sv =====
// Per-tick decode: debounce, train counting, timeout, credit and fare check.
// Holds the decoder state; depends on bpd_pkg.
`timescale 1ns / 1ps

module bpd_core (
  input  logic                  clk,
  input  logic                  rst,
  input  bpd_pkg::bpd_cfg_t     cfg,
  input  logic                  fire,
  input  bpd_pkg::bpd_item_t    item,
  output bpd_pkg::bpd_result_t  result
);
  import bpd_pkg::*;

  logic [TIME_WIDTH-1:0] ticks_since_pulse, ticks_since_pulse_next;
  logic [COUNT_W-1:0]    pulse_count, pulse_count_next;
  logic                  train_active, train_active_next;
  logic [CREDIT_W-1:0]   bill_total, bill_total_next;

  logic [TIME_WIDTH-1:0] elapsed;
  logic                  take_edge;
  logic                  train_end;
  logic [VALUE_W-1:0]    value;
  logic [CREDIT_W:0]     credit_sum;
  logic [CREDIT_W:0]     paid_sum;

  // Saturating tick counter and edge qualification
  assign elapsed   = (ticks_since_pulse == TIME_MAX) ? TIME_MAX : ticks_since_pulse + 1'b1;
  assign take_edge = item.edge_req & cfg.enable &
                     (32'(elapsed) > 32'(cfg.debounce_ticks));
  assign train_end = ~take_edge & train_active &
                     (32'(elapsed) > 32'(cfg.timeout_ticks));
  assign value     = train_end ? bill_value_of(pulse_count) : VALUE_NONE;

  // Saturating credit add
  assign credit_sum = {1'b0, bill_total} + (CREDIT_W+1)'(value);

  always_comb begin
    ticks_since_pulse_next = elapsed;
    pulse_count_next       = pulse_count;
    train_active_next      = train_active;
    bill_total_next        = bill_total;
    if (take_edge) begin
      ticks_since_pulse_next = '0;
      if (pulse_count != COUNT_MAX) pulse_count_next = pulse_count + 1'b1;
      train_active_next = 1'b1;
    end else if (train_end) begin
      bill_total_next   = credit_sum[CREDIT_W] ? CREDIT_MAX : credit_sum[CREDIT_W-1:0];
      pulse_count_next  = '0;
      train_active_next = 1'b0;
    end
  end

  // Fare check against the updated total
  assign paid_sum = {1'b0, bill_total_next} + {1'b0, item.coin_credit};

  always_comb begin
    result.bill_credit  = bill_total_next;
    result.bill_value   = value;
    result.unknown_bill = train_end & (value == VALUE_NONE);
    result.fare_paid    = train_end & (paid_sum >= {1'b0, cfg.fare});
  end

  // State registers, advanced once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_since_pulse <= TIME_MAX;
      pulse_count       <= '0;
      train_active      <= 1'b0;
      bill_total        <= '0;
    end else if (fire) begin
      ticks_since_pulse <= ticks_since_pulse_next;
      pulse_count       <= pulse_count_next;
      train_active      <= train_active_next;
      bill_total        <= bill_total_next;
    end
  end

endmodule

// ===== design/bill_pulse_train_decoder_unit.sv =====
// Bill pulse train decoder top level: input register, decode core, result
// register and configuration port. Depends on bpd_pkg, bpd_regs, bpd_core.
`timescale 1ns / 1ps

// Each input beat is one time tick of the bill acceptor's pulse line and
// yields exactly one result beat. The block sustains one beat per clock
// while the output is not stalled; a beat passes through an input register
// and then a result register, which holds its result while the output is
// stalled, until it is taken.
// The decode of one tick (debounce compare, timeout compare, credit add and
// fare compare) is a single combinational pass between those registers, and
// the decoder state advances once per tick. Configure through the APB port
// only while no beats are in flight.
module bill_pulse_train_decoder_unit (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpd_pkg::ADDR_W-1:0]    paddr,
  input  logic [bpd_pkg::DATA_W-1:0]    pwdata,
  output logic [bpd_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  // Tick input
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          edge_req,
  input  logic [bpd_pkg::CREDIT_W-1:0]  coin_credit,
  // Result output
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [bpd_pkg::CREDIT_W-1:0]  bill_credit,
  output logic [bpd_pkg::VALUE_W-1:0]   bill_value,
  output logic                          unknown_bill,
  output logic                          fare_paid
);
  import bpd_pkg::*;

  bpd_cfg_t    cfg;
  bpd_item_t   item_q;
  logic        item_q_valid;
  bpd_result_t core_result;
  bpd_result_t result_q;
  logic        out_free;
  logic        fire;
  logic        in_take;

  bpd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pipeline flow control
  assign out_free   = ~result_valid | ~result_stall;
  assign fire       = item_q_valid & out_free;
  assign item_stall = item_q_valid & ~out_free;
  assign in_take    = item_valid & ~item_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) item_q_valid <= 1'b0;
    else if (in_take) item_q_valid <= 1'b1;
    else if (fire) item_q_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_q.edge_req    <= edge_req;
      item_q.coin_credit <= coin_credit;
    end
  end

  bpd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (fire),
    .item   (item_q),
    .result (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (fire) result_valid <= 1'b1;
    else if (out_free) result_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (fire) result_q <= core_result;
  end

  assign bill_credit  = result_q.bill_credit;
  assign bill_value   = result_q.bill_value;
  assign unknown_bill = result_q.unknown_bill;
  assign fare_paid    = result_q.fare_paid;

endmodule
